FILE: src/bfs_pkg.sv
// Shared types, constants and a saturating add helper function for the background fit sum accumulator.
package bfs_pkg;

   // Build-time configuration
   localparam int COORD_BITS       = 11;
   localparam int PIXEL_BITS       = 16;
   localparam int RADIUS_FRAC_BITS = 8;

   // Fixed port and register widths
   localparam int POS_W       = 11;
   localparam int PIX_W       = 16;
   localparam int THR_W       = 16;
   localparam int CENTER_BITS = 11;
   localparam int COEF_W      = 32;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int IDX_W       = 4;
   localparam int SUM_W       = 64;
   localparam int COUNT_BITS  = 23;

   // Derived datapath widths
   localparam int DELTA_BITS = CENTER_BITS + 1;
   localparam int D2_BITS    = 2 * DELTA_BITS - 1;
   localparam int R_BITS     = (D2_BITS + 2 * RADIUS_FRAC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * R_BITS;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NUM_FIT    = 13;
   localparam int SIDX_W     = $clog2(NUM_FIT);
   localparam int STEP_W     = $clog2(R_BITS + 1);

   // Request queue between front and back
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_CENTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_K   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C   = 3'd7;

   // Fit term order (also the sum slot order)
   localparam logic [STEP_W-1:0] FT_Z     = STEP_W'(0);
   localparam logic [STEP_W-1:0] FT_ZR    = STEP_W'(1);
   localparam logic [STEP_W-1:0] FT_ZX    = STEP_W'(2);
   localparam logic [STEP_W-1:0] FT_ZY    = STEP_W'(3);
   localparam logic [STEP_W-1:0] FT_R     = STEP_W'(4);
   localparam logic [STEP_W-1:0] FT_X     = STEP_W'(5);
   localparam logic [STEP_W-1:0] FT_Y     = STEP_W'(6);
   localparam logic [STEP_W-1:0] FT_R2    = STEP_W'(7);
   localparam logic [STEP_W-1:0] FT_XR    = STEP_W'(8);
   localparam logic [STEP_W-1:0] FT_YR    = STEP_W'(9);
   localparam logic [STEP_W-1:0] FT_X2    = STEP_W'(10);
   localparam logic [STEP_W-1:0] FT_Y2    = STEP_W'(11);
   localparam logic [STEP_W-1:0] FT_XY    = STEP_W'(12);
   localparam logic [STEP_W-1:0] FT_DONE  = STEP_W'(13);

   // Residual sequence steps
   localparam logic [STEP_W-1:0] RS_AR    = STEP_W'(0);
   localparam logic [STEP_W-1:0] RS_BX    = STEP_W'(1);
   localparam logic [STEP_W-1:0] RS_CY    = STEP_W'(2);
   localparam logic [STEP_W-1:0] RS_LAST  = STEP_W'(3);
   localparam logic [STEP_W-1:0] RS_ERR   = STEP_W'(4);
   localparam logic [STEP_W-1:0] RS_MAG   = STEP_W'(5);
   localparam logic [STEP_W-1:0] RS_SQ    = STEP_W'(6);
   localparam logic [STEP_W-1:0] RS_ACC   = STEP_W'(7);

   // Square-of-distance steps
   localparam logic [STEP_W-1:0] D2_XX    = STEP_W'(0);
   localparam logic [STEP_W-1:0] D2_YY    = STEP_W'(1);

   // Last emitted index per pass
   localparam logic [STEP_W-1:0] EMIT_FIT_LAST = STEP_W'(NUM_FIT);
   localparam logic [STEP_W-1:0] EMIT_RES_LAST = STEP_W'(1);

   typedef struct packed {
      logic [THR_W-1:0]         low_threshold;
      logic [THR_W-1:0]         high_threshold;
      logic [CENTER_BITS-1:0]   x_center;
      logic [CENTER_BITS-1:0]   y_center;
      logic signed [COEF_W-1:0] coef_k;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } cfg_type;

   // Classified request handed from front to back
   typedef struct packed {
      logic                         func;
      logic                         in_win;
      logic                         last;
      logic [PIXEL_BITS-1:0]        z;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic signed [SUM_W-1:0] value;
      logic                    run_end;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_D2,
      BK_ROOT,
      BK_FIT,
      BK_RES,
      BK_EMIT
   } back_state_type;

   // Saturating signed 64-bit add
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W-1:0] s;
      begin
         s = a + b;
         if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
            s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
         end
         return s;
      end
   endfunction

endpackage

FILE: src/background_fit_sum_accumulator.sv
// Top level: register file, front end classifier and back end accumulator.
// A pixel inside the window passes the distance square and the bit-serial radius root,
// then uses the shared 33x33 multiplier one term per cycle; a skipped pixel bypasses them.
// The last pixel then emits 14 (fit) or 2 (residual) results, one per cycle while the
// two-entry result queue has room. A 4-deep request queue decouples input.
// Synchronous reset empties both queues, clears count and sums, restores register defaults.
module background_fit_sum_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_func,
   input  logic [bfs_pkg::POS_W-1:0]         req_x_pos,
   input  logic [bfs_pkg::POS_W-1:0]         req_y_pos,
   input  logic [bfs_pkg::PIX_W-1:0]         req_pixel_value,
   input  logic                              req_last_pixel,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [bfs_pkg::IDX_W-1:0]         rsp_sum_index,
   output logic signed [bfs_pkg::SUM_W-1:0]  rsp_sum_value,
   output logic                              rsp_run_end,
   input  logic                              csr_we,
   input  logic [bfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfs_pkg::CSR_W-1:0]         csr_wdata
);
   import bfs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid;
   item_type item;
   logic     item_take;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_THR:  cfg_in.low_threshold  = csr_wdata[THR_W-1:0];
            CSR_HIGH_THR: cfg_in.high_threshold = csr_wdata[THR_W-1:0];
            CSR_X_CENTER: cfg_in.x_center       = csr_wdata[CENTER_BITS-1:0];
            CSR_Y_CENTER: cfg_in.y_center       = csr_wdata[CENTER_BITS-1:0];
            CSR_COEF_K:   cfg_in.coef_k         = $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_A:   cfg_in.coef_a         = $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_B:   cfg_in.coef_b         = $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_C:   cfg_in.coef_c         = $signed(csr_wdata[COEF_W-1:0]);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= '0;
         cfg_ff.high_threshold <= '1;
         cfg_ff.x_center       <= CENTER_BITS'(1024);
         cfg_ff.y_center       <= CENTER_BITS'(1024);
         cfg_ff.coef_k         <= '0;
         cfg_ff.coef_a         <= '0;
         cfg_ff.coef_b         <= '0;
         cfg_ff.coef_c         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_pixel_value (req_pixel_value),
      .req_last_pixel  (req_last_pixel),
      .cfg             (cfg_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   bfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_sum_index (rsp_sum_index),
      .rsp_sum_value (rsp_sum_value),
      .rsp_run_end   (rsp_run_end)
   );

endmodule

FILE: src/bfs_front.sv
// Front end: accepts pixel requests, applies the window and center, queues them.
module bfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [10:0]        req_x_pos,
   input  logic [10:0]        req_y_pos,
   input  logic [15:0]        req_pixel_value,
   input  logic               req_last_pixel,
   input  bfs_pkg::cfg_type   cfg,
   output logic               item_valid,
   output bfs_pkg::item_type  item,
   input  logic               item_take
);
   import bfs_pkg::*;

   item_type            fq_mem [FQ_DEPTH];
   logic [FQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FQ_PTR_W:0]   cnt_ff, cnt_in;
   logic                push, pop;
   item_type            cls;
   logic [THR_W-1:0]    z_ext;

   // Classification of the incoming request
   always_comb begin
      z_ext      = THR_W'(req_pixel_value[PIXEL_BITS-1:0]);
      cls.func   = req_func;
      cls.last   = req_last_pixel;
      cls.z      = req_pixel_value[PIXEL_BITS-1:0];
      cls.in_win = (z_ext >= cfg.low_threshold) && (z_ext <= cfg.high_threshold);
      cls.dx     = $signed(DELTA_BITS'(req_x_pos[COORD_BITS-1:0]))
                 - $signed({1'b0, cfg.x_center});
      cls.dy     = $signed(DELTA_BITS'(req_y_pos[COORD_BITS-1:0]))
                 - $signed({1'b0, cfg.y_center});
   end

   // Queue control
   assign req_full   = (cnt_ff == (FQ_PTR_W+1)'(FQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = fq_mem[rd_ptr_ff];
   assign push       = req_push && !req_full;
   assign pop        = item_take && item_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fq_mem[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: src/bfs_back.sv
// Back end: radius root, shared multiplier, saturating sums and result emission.
module bfs_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfs_pkg::cfg_type                     cfg,
   input  logic                                 item_valid,
   input  bfs_pkg::item_type                    item,
   output logic                                 item_take,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [bfs_pkg::IDX_W-1:0]            rsp_sum_index,
   output logic signed [bfs_pkg::SUM_W-1:0]     rsp_sum_value,
   output logic                                 rsp_run_end
);
   import bfs_pkg::*;

   back_state_type          state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   item_type                item_ff, item_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff [NUM_FIT];
   logic signed [SUM_W-1:0] err_sum_ff, err_sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [D2_BITS-1:0]      d2_ff, d2_in;
   logic [RAD_BITS-1:0]     v_ff, v_in;
   logic [R_BITS+1:0]       rem_ff, rem_in;
   logic [R_BITS-1:0]       root_ff, root_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [31:0]             mag_ff, mag_in;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [MUL_W-1:0] z_op, r_op, dx_op, dy_op, one_op;
   logic signed [MUL_W-1:0] ka_op, kb_op, kc_op;
   logic [SIDX_W-1:0]       sidx;
   logic signed [SUM_W-1:0] sum_rd, sum_wdata;
   logic                    sum_we, sum_clr;
   logic signed [SUM_W-1:0] prod64, k_term, z_term, sq_term;
   logic [SUM_W-1:0]        mag_abs, mag_rnd;
   logic [D2_BITS-1:0]      d2_sum;
   logic [R_BITS+1:0]       rem_sh, trial;
   logic [STEP_W-1:0]       emit_last;

   // Output queue, two entries
   rsp_type  rq_mem [2];
   logic     rq_wr_ff, rq_rd_ff;
   logic [1:0] rq_cnt_ff;
   logic     rq_push, rq_pop;
   rsp_type  push_data;

   // Multiplier operands
   always_comb begin
      z_op   = $signed(MUL_W'(item_ff.z));
      r_op   = $signed(MUL_W'(root_ff));
      dx_op  = $signed({{(MUL_W-DELTA_BITS){item_ff.dx[DELTA_BITS-1]}}, item_ff.dx});
      dy_op  = $signed({{(MUL_W-DELTA_BITS){item_ff.dy[DELTA_BITS-1]}}, item_ff.dy});
      one_op = $signed(MUL_W'(1));
      ka_op  = $signed({{(MUL_W-COEF_W){cfg.coef_a[COEF_W-1]}}, cfg.coef_a});
      kb_op  = $signed({{(MUL_W-COEF_W){cfg.coef_b[COEF_W-1]}}, cfg.coef_b});
      kc_op  = $signed({{(MUL_W-COEF_W){cfg.coef_c[COEF_W-1]}}, cfg.coef_c});
      prod64 = $signed(prod_ff[SUM_W-1:0]);
      k_term = $signed({{(SUM_W-COEF_W){cfg.coef_k[COEF_W-1]}}, cfg.coef_k}) <<< 16;
      z_term = $signed(SUM_W'(item_ff.z)) <<< 24;
      sum_rd = sum_ff[sidx];
      emit_last = item_ff.func ? EMIT_RES_LAST : EMIT_FIT_LAST;
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer: next state, datapath updates
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      item_in    = item_ff;
      count_in   = count_ff;
      err_sum_in = err_sum_ff;
      d2_in      = d2_ff;
      v_in       = v_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      acc_in     = acc_ff;
      mag_in     = mag_ff;
      item_take  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      sidx       = '0;
      sum_we     = 1'b0;
      sum_clr    = 1'b0;
      sum_wdata  = '0;
      rq_push    = 1'b0;
      push_data  = '0;
      d2_sum     = '0;
      rem_sh     = '0;
      trial      = '0;
      mag_abs    = '0;
      mag_rnd    = '0;
      sq_term    = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               item_in   = item;
               step_in   = '0;
               if (item.in_win) begin
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = BK_D2;
               end else begin
                  state_in = item.last ? BK_EMIT : BK_IDLE;
               end
            end
         end
         BK_D2: begin
            // dx*dx, then dy*dy, then sum and load the root iteration
            unique case (step_ff)
               D2_XX: begin
                  mul_a   = dx_op;
                  mul_b   = dx_op;
                  step_in = step_ff + 1'b1;
               end
               D2_YY: begin
                  mul_a   = dy_op;
                  mul_b   = dy_op;
                  d2_in   = prod_ff[D2_BITS-1:0];
                  step_in = step_ff + 1'b1;
               end
               default: begin
                  d2_sum   = d2_ff + prod_ff[D2_BITS-1:0];
                  v_in     = RAD_BITS'(d2_sum) << (2 * RADIUS_FRAC_BITS);
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = '0;
                  state_in = BK_ROOT;
               end
            endcase
         end
         BK_ROOT: begin
            // One root bit per cycle, restoring method
            rem_sh  = {rem_ff[R_BITS-1:0], v_ff[RAD_BITS-1 -: 2]};
            trial   = {root_ff, 2'b01};
            v_in    = v_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[R_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[R_BITS-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(R_BITS - 1)) begin
               step_in  = '0;
               state_in = item_ff.func ? BK_RES : BK_FIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         BK_FIT: begin
            // Issue term k, accumulate term k-1
            unique case (step_ff)
               FT_Z:    begin mul_a = z_op;  mul_b = one_op; end
               FT_ZR:   begin mul_a = z_op;  mul_b = r_op;   end
               FT_ZX:   begin mul_a = z_op;  mul_b = dx_op;  end
               FT_ZY:   begin mul_a = z_op;  mul_b = dy_op;  end
               FT_R:    begin mul_a = r_op;  mul_b = one_op; end
               FT_X:    begin mul_a = dx_op; mul_b = one_op; end
               FT_Y:    begin mul_a = dy_op; mul_b = one_op; end
               FT_R2:   begin mul_a = r_op;  mul_b = r_op;   end
               FT_XR:   begin mul_a = r_op;  mul_b = dx_op;  end
               FT_YR:   begin mul_a = r_op;  mul_b = dy_op;  end
               FT_X2:   begin mul_a = dx_op; mul_b = dx_op;  end
               FT_Y2:   begin mul_a = dy_op; mul_b = dy_op;  end
               FT_XY:   begin mul_a = dx_op; mul_b = dy_op;  end
               default: begin mul_a = '0;    mul_b = '0;     end
            endcase
            if (step_ff != FT_Z) begin
               sidx      = SIDX_W'(step_ff - 1'b1);
               sum_we    = 1'b1;
               sum_wdata = sat_add(sum_rd, prod64);
            end
            if (step_ff == FT_DONE) begin
               step_in  = '0;
               state_in = item_ff.last ? BK_EMIT : BK_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         BK_RES: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               RS_AR: begin
                  mul_a = ka_op;
                  mul_b = r_op;
               end
               RS_BX: begin
                  mul_a  = kb_op;
                  mul_b  = dx_op;
                  acc_in = k_term + (prod64 <<< (8 - RADIUS_FRAC_BITS));
               end
               RS_CY: begin
                  mul_a  = kc_op;
                  mul_b  = dy_op;
                  acc_in = acc_ff + (prod64 <<< 8);
               end
               RS_LAST: begin
                  acc_in = acc_ff + (prod64 <<< 8);
               end
               RS_ERR: begin
                  acc_in = z_term - acc_ff;
               end
               RS_MAG: begin
                  // Round magnitude to 8 fraction bits, clamp to 32 bits
                  mag_abs = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
                  mag_rnd = (mag_abs + SUM_W'(16'h8000)) >> 16;
                  mag_in  = (mag_rnd[SUM_W-1:32] != '0) ? '1 : mag_rnd[31:0];
               end
               RS_SQ: begin
                  mul_a = $signed({1'b0, mag_ff});
                  mul_b = $signed({1'b0, mag_ff});
               end
               default: begin
                  sq_term    = (prod_ff[PROD_W-1:SUM_W-1] != '0) ? SUM_MAX : prod64;
                  err_sum_in = sat_add(err_sum_ff, sq_term);
                  step_in    = '0;
                  state_in   = item_ff.last ? BK_EMIT : BK_IDLE;
               end
            endcase
         end
         BK_EMIT: begin
            // Index 0 is the count, then the pass's sums
            if (step_ff != '0) begin
               sidx = SIDX_W'(step_ff - 1'b1);
            end
            push_data.idx     = IDX_W'(step_ff);
            push_data.run_end = (step_ff == emit_last);
            if (step_ff == '0) begin
               push_data.value = $signed(SUM_W'(count_ff));
            end else if (item_ff.func) begin
               push_data.value = err_sum_ff;
            end else begin
               push_data.value = sum_rd;
            end
            if (rq_cnt_ff != 2'd2) begin
               rq_push = 1'b1;
               if (push_data.run_end) begin
                  sum_clr    = 1'b1;
                  count_in   = '0;
                  err_sum_in = '0;
                  step_in    = '0;
                  state_in   = BK_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State and accumulated state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         step_ff    <= '0;
         count_ff   <= '0;
         err_sum_ff <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         count_ff   <= count_in;
         err_sum_ff <= err_sum_in;
      end
   end

   // Fit sums
   always_ff @(posedge clock) begin
      if (reset || sum_clr) begin
         for (int i = 0; i < NUM_FIT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (sum_we) begin
         sum_ff[sidx] <= sum_wdata;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      d2_ff   <= d2_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
   end

   // Result queue
   assign rq_pop        = rsp_pop && (rq_cnt_ff != 2'd0);
   assign rsp_empty     = (rq_cnt_ff == 2'd0);
   assign rsp_sum_index = rq_mem[rq_rd_ff].idx;
   assign rsp_sum_value = rq_mem[rq_rd_ff].value;
   assign rsp_run_end   = rq_mem[rq_rd_ff].run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         if (rq_push) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (rq_pop) begin
            rq_rd_ff <= !rq_rd_ff;
         end
         if (rq_push && !rq_pop) begin
            rq_cnt_ff <= rq_cnt_ff + 1'b1;
         end else if (rq_pop && !rq_push) begin
            rq_cnt_ff <= rq_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_mem[rq_wr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_rq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> rq_cnt_ff != 2'd2)
      else $error("result queue overflow");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ROOT) |-> (step_ff < STEP_W'(R_BITS)))
      else $error("root iteration overrun");

   a_fit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FIT) |-> (step_ff <= FT_DONE))
      else $error("fit step overrun");

   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (rq_push && push_data.run_end) |=> (count_ff == '0 && err_sum_ff == '0))
      else $error("state not cleared after emission");
`endif

endmodule
